@@ sv/cvm_pkg.sv @@
// Package: shared types, codes and reset values of the CO2 vent mode controller.
`default_nettype none
package cvm_pkg;

	// Event kinds carried by the func field
	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_MODE   = 2'd1;
	localparam logic [1:0] FUNC_MANUAL = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_CO2_OPEN     = 2'd0;
	localparam logic [1:0] CFG_CO2_COOLDOWN = 2'd1;
	localparam logic [1:0] CFG_TIMED_OPEN   = 2'd2;
	localparam logic [1:0] CFG_TIMED_CLOSED = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int PCNT_W     = 8;
	localparam int CCNT_W     = 9;

	// Reset values of the configuration registers
	localparam logic [CFG_DATA_W-1:0] RST_CO2_OPEN     = 8'd10;
	localparam logic [CFG_DATA_W-1:0] RST_CO2_COOLDOWN = 8'd5;
	localparam logic [CFG_DATA_W-1:0] RST_TIMED_OPEN   = 8'd5;
	localparam logic [CFG_DATA_W-1:0] RST_TIMED_CLOSED = 8'd10;

	typedef enum logic [1:0] {
		MODE_CO2    = 2'd0,
		MODE_TIMER  = 2'd1,
		MODE_MANUAL = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_OPEN = 2'd1,
		PH_COOL = 2'd2
	} phase_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] co2_open_ticks;
		logic [CFG_DATA_W-1:0] co2_cooldown_ticks;
		logic [CFG_DATA_W-1:0] timed_open_ticks;
		logic [CFG_DATA_W-1:0] timed_closed_ticks;
	} cfg_t;

	typedef struct packed {
		logic   vent_open;
		mode_t  op_mode;
		phase_t co2_phase;
	} status_t;

endpackage
`default_nettype wire

@@ sv/cvm_if.sv @@
// Interfaces: event and result channels of the CO2 vent mode controller.
`default_nettype none
interface cvm_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic       co2_above;

	modport source (output valid, func, co2_above, input ready);
	modport sink   (input valid, func, co2_above, output ready);
endinterface

interface cvm_res_if;
	logic       valid;
	logic       ready;
	logic       vent_open;
	logic [1:0] op_mode;
	logic [1:0] co2_phase;

	modport source (output valid, vent_open, op_mode, co2_phase, input ready);
	modport sink   (input valid, vent_open, op_mode, co2_phase, output ready);
endinterface
`default_nettype wire

@@ sv/co2_vent_mode_controller_top.sv @@
// Top level of the CO2 vent mode controller: config registers, core and result register.
//
// Usage:
//   evt carries one event word per handshake: func (0 tick, 1 mode button,
//   2 manual button) and co2_above, sampled only on a tick. res carries one
//   result word per event: vent_open, op_mode and co2_phase after the event.
//   The configuration port (cfg_we, cfg_index, cfg_wdata) writes one of the
//   four timing registers per cycle; write it only while no event is in flight.
//   The result of an event is registered: it is valid after the edge that
//   accepts it. One event is taken per cycle while the receiver keeps up, set by
//   the single result register, which refills in the cycle it is taken.
//   evt.ready is high while the result register is empty or being taken, so a
//   stalled receiver holds the result and stops new events, none are lost.
//   Reset clears the mode to CO2, the phase to waiting, both counters and the
//   servo drive, and loads the timing registers with 10, 5, 5 and 10.
`default_nettype none
module co2_vent_mode_controller_top
	import cvm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	cvm_evt_if.sink                    evt,
	cvm_res_if.source                  res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg;
	status_t nxt;
	status_t res_q;
	logic    res_valid_q;
	logic    step;

	cvm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Accept a word when the result register is free or drains this cycle
	assign evt.ready = !res_valid_q || res.ready;
	assign step      = evt.valid && evt.ready;

	cvm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.func      (evt.func),
		.co2_above (evt.co2_above),
		.cfg       (cfg),
		.nxt       (nxt)
	);

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= nxt;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.vent_open = res_q.vent_open;
	assign res.op_mode   = res_q.op_mode;
	assign res.co2_phase = res_q.co2_phase;

	// An accepted word always yields a result in the next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> res.valid)
		else $error("accepted event produced no result");

	// A tick in manual mode reports the vent open
	a_manual_open: assert property (@(posedge clk) disable iff (!arst_n)
		(step && evt.func == FUNC_TICK && res_valid_q && res_q.op_mode == MODE_MANUAL
			&& res.ready) |=> res.vent_open)
		else $error("manual tick did not open the vent");

	// A stalled result is not overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |-> !step)
		else $error("event accepted while result stalled");

endmodule
`default_nettype wire

@@ sv/cvm_cfg.sv @@
// Configuration register file: four 8-bit timing registers with a plain write port.
`default_nettype none
module cvm_cfg
	import cvm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.co2_open_ticks     <= RST_CO2_OPEN;
			cfg_q.co2_cooldown_ticks <= RST_CO2_COOLDOWN;
			cfg_q.timed_open_ticks   <= RST_TIMED_OPEN;
			cfg_q.timed_closed_ticks <= RST_TIMED_CLOSED;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CO2_OPEN:     cfg_q.co2_open_ticks     <= cfg_wdata;
				CFG_CO2_COOLDOWN: cfg_q.co2_cooldown_ticks <= cfg_wdata;
				CFG_TIMED_OPEN:   cfg_q.timed_open_ticks   <= cfg_wdata;
				CFG_TIMED_CLOSED: cfg_q.timed_closed_ticks <= cfg_wdata;
				default:          cfg_q                    <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ sv/cvm_core.sv @@
// Mode controller core: mode, CO2 phase, counters and servo state, updated once per word.
`default_nettype none
module cvm_core
	import cvm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [1:0] func,
	input  wire logic       co2_above,
	input  wire cfg_t       cfg,
	output status_t         nxt
);

	mode_t             mode_q, mode_d;
	phase_t            phase_q, phase_d;
	logic [PCNT_W-1:0] pcnt_q, pcnt_d;
	logic [CCNT_W-1:0] ccnt_q, ccnt_d;
	logic              servo_q, servo_d;
	logic [CCNT_W-1:0] span;

	// Timer cycle length, 9-bit sum of open and closed phases
	assign span = {1'b0, cfg.timed_open_ticks} + {1'b0, cfg.timed_closed_ticks};

	// Work out the state after this event
	always_comb begin
		mode_d  = mode_q;
		phase_d = phase_q;
		pcnt_d  = pcnt_q;
		ccnt_d  = ccnt_q;
		servo_d = servo_q;
		case (func)
			FUNC_TICK: begin
				unique case (mode_q)
					MODE_CO2: begin
						unique case (phase_q)
							PH_WAIT: begin
								if (co2_above) begin
									servo_d = 1'b1;
									phase_d = PH_OPEN;
									pcnt_d  = '0;
								end else begin
									servo_d = 1'b0;
								end
							end
							PH_OPEN: begin
								if (pcnt_q >= cfg.co2_open_ticks) begin
									servo_d = 1'b0;
									phase_d = PH_COOL;
									pcnt_d  = '0;
								end else begin
									pcnt_d = pcnt_q + 1'b1;
								end
							end
							PH_COOL: begin
								if (pcnt_q >= cfg.co2_cooldown_ticks) begin
									phase_d = PH_WAIT;
								end else begin
									pcnt_d = pcnt_q + 1'b1;
								end
							end
							default: phase_d = phase_q;
						endcase
					end
					MODE_TIMER: begin
						// Open up to the threshold, closed until the span, then wrap to one
						if (ccnt_q <= {1'b0, cfg.timed_open_ticks}) begin
							servo_d = 1'b1;
							ccnt_d  = ccnt_q + 1'b1;
						end else if (ccnt_q < span) begin
							servo_d = 1'b0;
							ccnt_d  = ccnt_q + 1'b1;
						end else begin
							ccnt_d = {{(CCNT_W-1){1'b0}}, 1'b1};
						end
					end
					MODE_MANUAL: servo_d = 1'b1;
					default:     servo_d = servo_q;
				endcase
			end
			FUNC_MODE: begin
				if (mode_q == MODE_CO2) begin
					mode_d = MODE_TIMER;
					ccnt_d = '0;
				end else if (mode_q != MODE_MANUAL) begin
					mode_d  = MODE_CO2;
					phase_d = PH_WAIT;
					pcnt_d  = '0;
					ccnt_d  = '0;
				end
			end
			FUNC_MANUAL: begin
				if (mode_q == MODE_MANUAL) begin
					mode_d  = MODE_CO2;
					phase_d = PH_WAIT;
					pcnt_d  = '0;
					ccnt_d  = '0;
				end else begin
					mode_d = MODE_MANUAL;
				end
			end
			default: mode_d = mode_q;
		endcase
	end

	// Advance the state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_CO2;
			phase_q <= PH_WAIT;
			pcnt_q  <= '0;
			ccnt_q  <= '0;
			servo_q <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			pcnt_q  <= pcnt_d;
			ccnt_q  <= ccnt_d;
			servo_q <= servo_d;
		end
	end

	assign nxt.vent_open = servo_d;
	assign nxt.op_mode   = mode_d;
	assign nxt.co2_phase = phase_d;

endmodule
`default_nettype wire
